[src/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables the check.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

// Implication that must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

[src/hcds_pkg.sv]
// Types and constants of the comment and docstring stripper.
package hcds_pkg;

	// Command codes of an input item.
	localparam logic CMD_TEXT = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_COMMENT_CHAR = 1'b0;
	localparam logic CFG_QUOTE_CHAR   = 1'b1;

	// Register reset values and fixed bytes.
	localparam logic [7:0] COMMENT_CHAR_RST = 8'd35;
	localparam logic [7:0] QUOTE_CHAR_RST   = 8'd34;
	localparam logic [7:0] LINE_END_BYTE    = 8'd10;
	localparam logic [7:0] SPACE_BYTE       = 8'd32;

	// Most results one input item can cause.
	localparam int MAX_RESULTS = 4;

	typedef struct packed {
		logic       command;
		logic [7:0] byte_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       is_terminator;
		logic       last_of_run;
	} out_item_t;

	// One pending result without its position flag.
	typedef struct packed {
		logic [7:0] data;
		logic       term;
	} res_slot_t;

	// All results of one item, handed from the core to the result queue.
	typedef struct packed {
		logic                              valid;
		logic [$clog2(MAX_RESULTS+1)-1:0]  cnt;
		res_slot_t [MAX_RESULTS-1:0]       slots;
	} res_bundle_t;

endpackage

[src/hcds_core.sv]
// Stripper state, configuration registers and per-item result decode.
module hcds_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                item_valid,
	input  hcds_pkg::in_item_t  item,
	input  logic                advance,
	output hcds_pkg::res_bundle_t bundle
);

	logic [7:0] comment_char_q;
	logic [7:0] quote_char_q;
	logic       in_comment_q;
	logic       in_doc_q;
	logic [1:0] quote_run_q;
	logic       space_held_q;

	logic       in_comment_d;
	logic       in_doc_d;
	logic [1:0] quote_run_d;
	logic       space_held_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_char_q <= hcds_pkg::COMMENT_CHAR_RST;
			quote_char_q   <= hcds_pkg::QUOTE_CHAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hcds_pkg::CFG_COMMENT_CHAR: comment_char_q <= cfg_data;
				hcds_pkg::CFG_QUOTE_CHAR:   quote_char_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode one item into its results and the next state.
	always_comb begin
		logic       emit_space;
		logic [1:0] num_quotes;
		logic       emit_last;
		logic [7:0] last_data;
		logic       last_term;
		logic [2:0] k;
		logic [1:0] pending;

		pending      = (quote_run_q == 2'd3) ? 2'd2 : quote_run_q;
		emit_space   = 1'b0;
		num_quotes   = 2'd0;
		emit_last    = 1'b0;
		last_data    = item.byte_in;
		last_term    = 1'b0;
		in_comment_d = in_comment_q;
		in_doc_d     = in_doc_q;
		quote_run_d  = quote_run_q;
		space_held_d = space_held_q;

		if (item.command == hcds_pkg::CMD_END) begin
			// Flush pending quotes outside a comment or docstring, then the terminator; all state clears.
			num_quotes   = (!in_doc_q && !in_comment_q) ? pending : 2'd0;
			emit_last    = 1'b1;
			last_data    = 8'd0;
			last_term    = 1'b1;
			in_comment_d = 1'b0;
			in_doc_d     = 1'b0;
			quote_run_d  = 2'd0;
			space_held_d = 1'b0;
		end else begin
			emit_space   = space_held_q;
			space_held_d = 1'b0;
			if (item.byte_in == hcds_pkg::LINE_END_BYTE) begin
				in_comment_d = 1'b0;
				num_quotes   = in_doc_q ? 2'd0 : pending;
				space_held_d = !in_doc_q;
				quote_run_d  = 2'd0;
			end else if (in_comment_q) begin
				// Rest of the line is dropped.
			end else if (item.byte_in == comment_char_q) begin
				in_comment_d = 1'b1;
				num_quotes   = in_doc_q ? 2'd0 : pending;
				quote_run_d  = 2'd0;
			end else if (item.byte_in == quote_char_q) begin
				if (quote_run_q >= 2'd2) begin
					in_doc_d    = !in_doc_q;
					quote_run_d = 2'd0;
				end else begin
					quote_run_d = quote_run_q + 2'd1;
				end
			end else if (in_doc_q) begin
				quote_run_d = 2'd0;
			end else begin
				num_quotes  = pending;
				emit_last   = 1'b1;
				quote_run_d = 2'd0;
			end
		end

		// Pack the results in order: space, quotes, then byte or terminator.
		k = 3'd0;
		bundle.slots = '0;
		if (emit_space) begin
			bundle.slots[k[1:0]] = '{data: hcds_pkg::SPACE_BYTE, term: 1'b0};
			k = k + 3'd1;
		end
		for (int i = 0; i < 2; i++) begin
			if (2'(i) < num_quotes) begin
				bundle.slots[k[1:0]] = '{data: quote_char_q, term: 1'b0};
				k = k + 3'd1;
			end
		end
		if (emit_last) begin
			bundle.slots[k[1:0]] = '{data: last_data, term: last_term};
			k = k + 3'd1;
		end
		bundle.cnt   = k;
		bundle.valid = item_valid;
	end

	// State advances when the item moves into the result queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q <= 1'b0;
			in_doc_q     <= 1'b0;
			quote_run_q  <= 2'd0;
			space_held_q <= 1'b0;
		end else if (advance) begin
			in_comment_q <= in_comment_d;
			in_doc_q     <= in_doc_d;
			quote_run_q  <= quote_run_d;
			space_held_q <= space_held_d;
		end
	end

endmodule

[src/hcds_outq.sv]
// Result queue that plays out the results of one item, one per cycle while out_stall is low.
module hcds_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hcds_pkg::res_bundle_t bundle,
	output logic                  free,
	output logic                  out_valid,
	input  logic                  out_stall,
	output hcds_pkg::out_item_t   out_data
);

	localparam int CntW = $clog2(hcds_pkg::MAX_RESULTS + 1);
	localparam int PtrW = $clog2(hcds_pkg::MAX_RESULTS);

	hcds_pkg::res_slot_t [hcds_pkg::MAX_RESULTS-1:0] slots_q;
	logic [CntW-1:0] cnt_q;
	logic [PtrW-1:0] rd_q;
	logic            xfer;

	assign out_valid = (cnt_q != '0);
	assign xfer      = out_valid && !out_stall;
	// Room for a new item once the last pending result leaves.
	assign free      = (cnt_q == '0) || ((cnt_q == CntW'(1)) && xfer);

	assign out_data.byte_out      = slots_q[rd_q].data;
	assign out_data.is_terminator = slots_q[rd_q].term;
	assign out_data.last_of_run   = (cnt_q == CntW'(1));

	// Count and read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (free && bundle.valid) begin
			cnt_q <= bundle.cnt;
			rd_q  <= '0;
		end else if (xfer) begin
			cnt_q <= cnt_q - CntW'(1);
			rd_q  <= rd_q + PtrW'(1);
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (free && bundle.valid) begin
			slots_q <= bundle.slots;
		end
	end

endmodule

[src/hash_comment_docstring_stripper_unit.sv]
// Top level of the comment and docstring stripper.
// A result passes through the input register and then the result queue.
// Throughput: one item per cycle while each item yields at most one result and out_stall is low.
// An item that yields k results holds the result queue until all k have left (k is at most four).
// Reset clears the input valid flag, the queue count and all stripper state; the comment and
// quote registers return to '#' and '"'.
module hash_comment_docstring_stripper_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  hcds_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output hcds_pkg::out_item_t out_data
);

	logic                  in_valid_s1;
	hcds_pkg::in_item_t    in_item_s1;
	hcds_pkg::res_bundle_t bundle;
	logic                  free;
	logic                  advance;

	assign advance  = in_valid_s1 && free;
	assign in_stall = in_valid_s1 && !free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_item_s1 <= in_data;
		end
	end

	hcds_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (in_valid_s1),
		.item       (in_item_s1),
		.advance    (advance),
		.bundle     (bundle)
	);

	hcds_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[src/hcds_checker.sv]
// Port-level checks for the comment and docstring stripper.
`include "assert_macros.svh"

module hcds_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input hcds_pkg::out_item_t out_data
);

	// A stalled result stays valid and unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// A terminator always closes its item's results.
	`ASSERT_IMPL(a_term_last, clk, arst_n, out_valid && out_data.is_terminator, out_data.last_of_run, "terminator not last")

	// A terminator carries a zero byte.
	`ASSERT_IMPL(a_term_zero, clk, arst_n, out_valid && out_data.is_terminator, out_data.byte_out == 8'd0, "terminator byte not zero")

	// More results of the same item follow a result that is not the last.
	`ASSERT_NEXT(a_run_cont, clk, arst_n, out_valid && !out_data.last_of_run, out_valid, "item results cut short")

endmodule

bind hash_comment_docstring_stripper_unit hcds_checker u_hcds_checker (.*);
